// ===== src/task_timeout_queue_core_assert.svh =====
// Assertion macros used by the checker file of the timer queue core.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef TASK_TIMEOUT_QUEUE_CORE_ASSERT_SVH
`define TASK_TIMEOUT_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, off during reset
`define TTQ_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("timer queue check failed");

// Next-cycle implication, off during reset
`define TTQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("timer queue check failed");

`endif

// ===== src/ttq_pkg.sv =====
// Package of the timer queue core: widths, codes and the cell command type.
// No dependencies; used by every module of the core.
package ttq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TASK_W  = 8;
  localparam int TIME_W  = 31;
  localparam int WAKE_W  = 32;
  localparam int IN_DATA_W  = 72;  // task, timeout, now, padded
  localparam int OUT_DATA_W = 40;  // task, delay, padded

  localparam logic [TIME_W-1:0] MAX_DELAY = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_ALARM    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_READY = 2'd0,
    KIND_ALARM = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SCAN    = 2'd1,
    ST_RELEASE = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // Broadcast to every cell in a cycle
  typedef struct packed {
    cell_op_t            op;
    logic [WAKE_W-1:0]   wake;
    logic [TASK_W-1:0]   task_id;
  } cell_cmd_t;

endpackage

// ===== src/ttq_cell.sv =====
// One slot of the sorted timer queue: a wake time and a task number.
// Depends on ttq_pkg; neighbors are wired by the top level.
module ttq_cell #(
  parameter int QUEUE_DEPTH = ttq_pkg::QUEUE_DEPTH_DEF,
  parameter int IDX         = 0,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1),
  parameter int IW          = $clog2(QUEUE_DEPTH)
) (
  input  logic                       clk,
  input  ttq_pkg::cell_cmd_t         cmd,
  input  logic [CW-1:0]              cnt,
  input  logic [IW-1:0]              pos,
  input  logic                       left_gt,
  input  logic [ttq_pkg::WAKE_W-1:0] left_wake,
  input  logic [ttq_pkg::TASK_W-1:0] left_task,
  input  logic [ttq_pkg::WAKE_W-1:0] right_wake,
  input  logic [ttq_pkg::TASK_W-1:0] right_task,
  output logic [ttq_pkg::WAKE_W-1:0] wake,
  output logic [ttq_pkg::TASK_W-1:0] task_id,
  output logic                       gt,
  output logic                       match
);
  import ttq_pkg::*;

  logic              occupied;
  logic [WAKE_W-1:0] wake_next;
  logic [TASK_W-1:0] task_next;

  assign occupied = CW'(IDX) < cnt;
  // Empty slots and later wake times both count as "after" the new entry
  assign gt    = !(occupied && (wake <= cmd.wake));
  assign match = (task_id == cmd.task_id);

  // Insert: first "after" slot takes the new entry, the rest shift right
  always_comb begin
    wake_next = wake;
    task_next = task_id;
    case (cmd.op)
      CELL_INSERT: begin
        if (gt) begin
          if (left_gt) begin
            wake_next = left_wake;
            task_next = left_task;
          end else begin
            wake_next = cmd.wake;
            task_next = cmd.task_id;
          end
        end
      end
      CELL_REMOVE: begin
        if (IW'(IDX) >= pos) begin
          wake_next = right_wake;
          task_next = right_task;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    wake    <= wake_next;
    task_id <= task_next;
  end

endmodule

// ===== src/ttq_ctrl.sv =====
// Sequencer of the timer queue: request decode, cancel scan, release walk,
// entry count and the output register. Depends on ttq_pkg.
module ttq_ctrl #(
  parameter int QUEUE_DEPTH = ttq_pkg::QUEUE_DEPTH_DEF,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1),
  parameter int IW          = $clog2(QUEUE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ttq_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ttq_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic [ttq_pkg::WAKE_W-1:0]    head_wake,
  input  logic [ttq_pkg::TASK_W-1:0]    head_task,
  input  logic [QUEUE_DEPTH-1:0]        match,
  output ttq_pkg::cell_cmd_t            cmd,
  output logic [CW-1:0]                 cnt,
  output logic [IW-1:0]                 pos
);
  import ttq_pkg::*;

  state_t            state, state_next;
  logic [CW-1:0]     cnt_next;
  logic [CW-1:0]     idx, idx_next;
  logic [TASK_W-1:0] req_task;
  logic [TIME_W-1:0] req_now;

  logic [TASK_W-1:0] in_task;
  logic [TIME_W-1:0] in_timeout;
  logic [TIME_W-1:0] in_now;
  logic [WAKE_W-1:0] in_wake;
  logic [WAKE_W-1:0] diff;
  logic [TIME_W-1:0] next_delay;
  logic              out_free;
  logic              accept;

  logic              ld;
  kind_t             ld_kind;
  logic [TASK_W-1:0] ld_task;
  logic [TIME_W-1:0] ld_delay;
  logic              ld_last;

  kind_t             out_kind;
  logic [TASK_W-1:0] out_task;
  logic [TIME_W-1:0] out_delay;

  assign in_task    = s_tdata[TASK_W-1:0];
  assign in_timeout = s_tdata[TASK_W +: TIME_W];
  assign in_now     = s_tdata[TASK_W+TIME_W +: TIME_W];
  assign in_wake    = {1'b0, in_now} + {1'b0, in_timeout};

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // Delay to the head once nothing more is due, saturated to 31 bits
  assign diff = head_wake - {1'b0, req_now};
  always_comb begin
    if (cnt == '0) begin
      next_delay = '0;
    end else if (diff[WAKE_W-1]) begin
      next_delay = MAX_DELAY;
    end else begin
      next_delay = diff[TIME_W-1:0];
    end
  end

  // Next state, cell command and result load
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    idx_next    = idx;
    cmd.op      = CELL_HOLD;
    cmd.wake    = in_wake;
    cmd.task_id = (state == ST_IDLE) ? in_task : req_task;
    pos         = '0;
    ld          = 1'b0;
    ld_kind     = KIND_READY;
    ld_task     = '0;
    ld_delay    = '0;
    ld_last     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(s_tuser))
            OP_SCHEDULE: begin
              if (in_timeout == '0) begin
                ld      = 1'b1;
                ld_kind = KIND_READY;
                ld_task = in_task;
                ld_last = 1'b1;
              end else if (cnt == CW'(QUEUE_DEPTH)) begin
                ld      = 1'b1;
                ld_kind = KIND_FULL;
                ld_last = 1'b1;
              end else begin
                cmd.op   = CELL_INSERT;
                cnt_next = cnt + 1'b1;
                if ((cnt == '0) || (in_wake < head_wake)) begin
                  ld       = 1'b1;
                  ld_kind  = KIND_ALARM;
                  ld_delay = in_timeout;
                  ld_last  = 1'b1;
                end
              end
            end
            OP_CANCEL: begin
              idx_next   = '0;
              state_next = ST_SCAN;
            end
            OP_ALARM: begin
              state_next = ST_RELEASE;
            end
            default: begin
            end
          endcase
        end
      end
      // Walk the slots for the earliest entry of the task
      ST_SCAN: begin
        if (idx == cnt) begin
          state_next = ST_RELEASE;
        end else if (match[idx[IW-1:0]]) begin
          cmd.op     = CELL_REMOVE;
          pos        = idx[IW-1:0];
          cnt_next   = cnt - 1'b1;
          state_next = ST_RELEASE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      // Pop due entries one per result, then report the next alarm
      ST_RELEASE: begin
        if (out_free) begin
          ld = 1'b1;
          if ((cnt != '0) && (head_wake <= {1'b0, req_now})) begin
            ld_kind  = KIND_READY;
            ld_task  = head_task;
            cmd.op   = CELL_REMOVE;
            pos      = '0;
            cnt_next = cnt - 1'b1;
          end else begin
            ld_kind    = KIND_ALARM;
            ld_delay   = next_delay;
            ld_last    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (ld) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      req_task <= in_task;
      req_now  <= in_now;
    end
    if (ld) begin
      out_kind  <= ld_kind;
      out_task  <= ld_task;
      out_delay <= ld_delay;
      m_tlast   <= ld_last;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {{(OUT_DATA_W-TASK_W-TIME_W){1'b0}}, out_delay, out_task};

endmodule

// ===== src/task_timeout_queue_core.sv =====
// Top level of the sorted timer queue: a row of queue cells and the sequencer.
// Depends on ttq_pkg, ttq_cell and ttq_ctrl.
//
//  channel | direction | payload
//  s_*     | in        | tuser: operation; tdata: task_id, timeout, now
//  m_*     | out       | tuser: kind; tdata: ready_task, alarm_delay; tlast: last
//
// A schedule is inserted by all cells at once.
// Cancel scans one cell a cycle for the task's first entry, then releases due
// tasks one per result and ends with the alarm result. Alarm expiry skips the scan.
// A new request is taken once the sequencer is idle and the output register is
// free or being drained. Output stalls hold the release walk.
// Reset clears the state, the entry count and the output valid; no clearing pass is run.
module task_timeout_queue_core #(
  parameter int QUEUE_DEPTH = ttq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ttq_pkg::IN_DATA_W-1:0]  s_tdata,   // task_id[7:0], timeout[38:8], now[69:39]
  input  logic [1:0]                     s_tuser,   // operation[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ttq_pkg::OUT_DATA_W-1:0] m_tdata,   // ready_task[7:0], alarm_delay[38:8]
  output logic [1:0]                     m_tuser,   // kind[1:0]
  output logic                           m_tlast
);
  import ttq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  cell_cmd_t                    cmd;
  logic [CW-1:0]                cnt;
  logic [IW-1:0]                pos;
  logic [WAKE_W-1:0]            wake_arr [QUEUE_DEPTH];
  logic [TASK_W-1:0]            task_arr [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       gt_vec;
  logic [QUEUE_DEPTH-1:0]       match_vec;

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              l_gt;
    logic [WAKE_W-1:0] l_wake;
    logic [TASK_W-1:0] l_task;
    logic [WAKE_W-1:0] r_wake;
    logic [TASK_W-1:0] r_task;

    if (i == 0) begin : g_first
      assign l_gt   = 1'b0;
      assign l_wake = wake_arr[i];
      assign l_task = task_arr[i];
    end else begin : g_mid
      assign l_gt   = gt_vec[i-1];
      assign l_wake = wake_arr[i-1];
      assign l_task = task_arr[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_wake = wake_arr[i];
      assign r_task = task_arr[i];
    end else begin : g_inner
      assign r_wake = wake_arr[i+1];
      assign r_task = task_arr[i+1];
    end

    ttq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (i),
      .CW          (CW),
      .IW          (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cnt        (cnt),
      .pos        (pos),
      .left_gt    (l_gt),
      .left_wake  (l_wake),
      .left_task  (l_task),
      .right_wake (r_wake),
      .right_task (r_task),
      .wake       (wake_arr[i]),
      .task_id    (task_arr[i]),
      .gt         (gt_vec[i]),
      .match      (match_vec[i])
    );
  end

  ttq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CW          (CW),
    .IW          (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .head_wake (wake_arr[0]),
    .head_task (task_arr[0]),
    .match     (match_vec),
    .cmd       (cmd),
    .cnt       (cnt),
    .pos       (pos)
  );

endmodule

// ===== src/ttq_checker.sv =====
// Port-level checks of the timer queue core, bound to the top level.
// Depends on ttq_pkg and task_timeout_queue_core_assert.svh.
`include "task_timeout_queue_core_assert.svh"

module ttq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [ttq_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [1:0]                     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ttq_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser,
  input logic                           m_tlast
);
  import ttq_pkg::*;

  logic in_acc;
  logic zero_sched;
  logic walk_req;

  assign in_acc     = s_tvalid && s_tready;
  assign zero_sched = in_acc && (s_tuser == OP_SCHEDULE) &&
                      (s_tdata[TASK_W +: TIME_W] == '0);
  assign walk_req   = in_acc && ((s_tuser == OP_CANCEL) || (s_tuser == OP_ALARM));

  // Zero-timeout schedule comes straight back as the same task, alone
  `TTQ_ASSERT_NEXT(a_zero_ready, zero_sched, m_tvalid && (m_tuser == KIND_READY) && m_tlast && (m_tdata[TASK_W-1:0] == $past(s_tdata[TASK_W-1:0])))

  // Cancel or expiry keeps the input closed while the queue is walked
  `TTQ_ASSERT_NEXT(a_walk_busy, walk_req, !s_tready)

  // Only released tasks can be followed by more results of a request
  `TTQ_ASSERT_IMPL(a_last_kind, m_tvalid && (m_tuser != KIND_READY), m_tlast)

  // A stalled result holds
  `TTQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind task_timeout_queue_core ttq_checker u_ttq_checker (.*);
